/* rtl/tdpt_pkg.sv */
// ---------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types for the trial division prime test.
// ---------------------------------------------------------------------------
package tdpt_pkg;

  localparam int NUM_WIDTH_DEF = 32;  // default test width
  localparam int CAND_WIDTH    = 32;  // width of the request and echo fields

  localparam int SMALL_PRIME_LO = 2;
  localparam int SMALL_PRIME_HI = 3;
  localparam int FIRST_DIVISOR  = 5;  // first 6k-1 divisor
  localparam int PAIR_GAP       = 2;  // 6k+1 = (6k-1) + 2
  localparam int WHEEL_STEP     = 6;

  // status returned by the remainder unit
  typedef struct packed {
    logic done;      // one-cycle pulse at the end of a remainder
    logic rem_zero;  // remainder is zero, valid with done
  } tdpt_div_status_t;

endpackage

/* rtl/tdpt_rem_unit.sv */
// ---------------------------------------------------------------------------
// tdpt_rem_unit
// Restoring bit-serial remainder unit: one dividend bit per cycle.
// ---------------------------------------------------------------------------
module tdpt_rem_unit
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,  // held stable while busy
  input  logic [NUM_WIDTH-1:0] divisor,   // held stable while busy
  output tdpt_div_status_t     status
);

  localparam int CNT_W = $clog2(NUM_WIDTH);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [NUM_WIDTH-1:0] rem;
  logic [NUM_WIDTH-1:0] rem_next;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;

  // shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, dividend[cnt]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[NUM_WIDTH-1:0];
    end else begin
      rem_next = trial[NUM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      cnt <= CNT_W'(NUM_WIDTH - 1);
    end else if (busy) begin
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

/* rtl/trial_division_prime_test.sv */
// ---------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by 6k+-1 trial division on a shared serial remainder unit.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with candidate. A request is taken
//   when in_valid is high and in_stall is low; in_stall is high unless
//   the sequencer is idle. Bits of candidate above NUM_WIDTH are ignored.
//   Output channel: out_valid / out_stall with candidate_echo and
//   prime_flag; one result per request, held in an output register until
//   the receiver takes it. A new request is taken while a result waits.
// Steps: 2, 3, n < 2, even n and multiples of 3 are settled by the screen
//   state alone. Otherwise divisor pairs (6k-1, 6k+1) are tried, two
//   remainders on the serial unit per pair, until d*d > n or a divisor
//   is found (about sqrt(n)/6 pairs for a prime). The serial remainder
//   unit sets the pace, so a large prime takes far longer than most
//   composites.
// Throughput: one request at a time; the next one can be taken at the
//   edge after out_valid rises.
// Reset: synchronous, returns to idle and drops out_valid.
// Stall: a finished result waits in the sequencer while the output
//   register is still held by a stalled receiver.
// ---------------------------------------------------------------------------
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CAND_WIDTH-1:0] candidate,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CAND_WIDTH-1:0] candidate_echo,
  output logic                  prime_flag
);

  localparam int SQ_W    = NUM_WIDTH + 2;        // room for d*d just past the bound
  localparam int NIB_CNT = (NUM_WIDTH + 3) / 4;  // nibbles in the mod-3 fold

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCREEN,
    S_LOOP,
    S_DIV_LO,
    S_DIV_HI,
    S_DONE
  } state_t;

  state_t state;

  logic [NUM_WIDTH-1:0]  cand_n;     // request masked to the test width
  logic [CAND_WIDTH-1:0] cand_echo;  // masked request cut to echo width
  logic [NUM_WIDTH-1:0]  n;          // number under test
  logic [CAND_WIDTH-1:0] echo;
  logic [NUM_WIDTH-1:0]  d;          // current 6k-1 divisor
  logic [SQ_W-1:0]       sq;         // d*d, kept by increments
  logic [SQ_W-1:0]       sq_next;
  logic [NUM_WIDTH-1:0]  divisor;
  logic                  div_start;
  logic                  verdict;
  logic                  accept;
  logic                  out_free;
  tdpt_div_status_t      div_status;

  // n mod 3 by digit folding: 16 and 4 are both 1 mod 3, so nibble and
  // bit-pair sums keep the residue.
  function automatic logic [1:0] mod3(input logic [NUM_WIDTH-1:0] v);
    logic [4*NIB_CNT-1:0] padded;
    logic [7:0]           nsum;
    logic [4:0]           f1;
    logic [2:0]           f2;
    logic [2:0]           f3;
    padded = (4*NIB_CNT)'(v);
    nsum   = '0;
    for (int i = 0; i < NIB_CNT; i++) begin
      nsum = nsum + 8'(padded[4*i +: 4]);
    end
    f1 = 5'(nsum[7:4]) + 5'(nsum[3:0]);                  // <= 30
    f2 = 3'(f1[4]) + 3'(f1[3:2]) + 3'(f1[1:0]);          // <= 7
    f3 = 3'(f2[2]) + 3'(f2[1:0]);                        // <= 4
    return (f3 >= 3'd3) ? 2'(f3 - 3'd3) : f3[1:0];
  endfunction

  generate
    if (NUM_WIDTH >= CAND_WIDTH) begin : g_wide
      assign cand_n    = NUM_WIDTH'(candidate);
      assign cand_echo = candidate;
    end else begin : g_narrow
      assign cand_n    = candidate[NUM_WIDTH-1:0];
      assign cand_echo = CAND_WIDTH'(cand_n);
    end
  endgenerate

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // (d+6)^2 = d^2 + 12d + 36
  always_comb begin
    sq_next = sq + (SQ_W'(d) << 3) + (SQ_W'(d) << 2)
            + SQ_W'(WHEEL_STEP * WHEEL_STEP);
  end

  tdpt_rem_unit #(
    .NUM_WIDTH (NUM_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (divisor),
    .status   (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // output register: load a finished result, or drop a taken one
      if (state == S_DONE && out_free) begin
        out_valid      <= 1'b1;
        candidate_echo <= echo;
        prime_flag     <= verdict;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            n     <= cand_n;
            echo  <= cand_echo;
            state <= S_SCREEN;
          end
        end
        S_SCREEN: begin
          if (n == NUM_WIDTH'(SMALL_PRIME_LO) || n == NUM_WIDTH'(SMALL_PRIME_HI)) begin
            verdict <= 1'b1;
            state   <= S_DONE;
          end else if (n < NUM_WIDTH'(SMALL_PRIME_LO) || !n[0] || mod3(n) == 2'd0) begin
            verdict <= 1'b0;
            state   <= S_DONE;
          end else begin
            d     <= NUM_WIDTH'(FIRST_DIVISOR);
            sq    <= SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          // bound test at full width: stop once d*d > n
          if (sq > SQ_W'(n)) begin
            verdict <= 1'b1;
            state   <= S_DONE;
          end else begin
            divisor   <= d;
            div_start <= 1'b1;
            state     <= S_DIV_LO;
          end
        end
        S_DIV_LO: begin
          if (div_status.done) begin
            if (div_status.rem_zero) begin
              verdict <= 1'b0;
              state   <= S_DONE;
            end else begin
              divisor   <= d + NUM_WIDTH'(PAIR_GAP);
              div_start <= 1'b1;
              state     <= S_DIV_HI;
            end
          end
        end
        S_DIV_HI: begin
          if (div_status.done) begin
            if (div_status.rem_zero) begin
              verdict <= 1'b0;
              state   <= S_DONE;
            end else begin
              d     <= d + NUM_WIDTH'(WHEEL_STEP);
              sq    <= sq_next;
              state <= S_LOOP;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
